@@ design/tlw_pkg.sv @@
package tlw_pkg;

    // Byte codes the wrapper treats specially
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_TAKE,
        ST_LOAD
    } tlw_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic issue;
        logic take;
        logic load;
    } tlw_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic more;
        logic pend_one;
        logic pend_any;
        logic out_free;
    } tlw_status_t;

    // Letters and digits are word bytes, everything else is a break
    function automatic logic is_word(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h5a)) ||
               ((c >= 8'h61) && (c <= 8'h7a));
    endfunction

endpackage

@@ design/tlw_ram.sv @@
module tlw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 82
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/tlw_datapath.sv @@
module tlw_datapath import tlw_pkg::*; #(
    parameter int LINE_WIDTH = 80
) (
    input  logic        clk,
    input  logic        rst_n,
    input  tlw_cmd_t    cmd,
    output tlw_status_t status,
    input  logic [7:0]  ch,
    input  logic        last_byte,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [7:0]  char_first,
    output logic [7:0]  char_second,
    output logic [1:0]  pair_count,
    output logic        end_of_run
);

    localparam int BUF_DEPTH = LINE_WIDTH + 2;
    localparam int PTR_W     = $clog2(BUF_DEPTH);
    localparam int LEN_W     = $clog2(LINE_WIDTH + 3);
    localparam int SUM_W     = LEN_W + 1;

    // Circular buffer position: base plus offset, folded once
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                  input logic [LEN_W-1:0] ofs);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(ofs);
        if (sum >= SUM_W'(BUF_DEPTH))
        begin
            sum = sum - SUM_W'(BUF_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // Line tracking state
    logic [LEN_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0] start_reg, start_next;
    logic [LEN_W-1:0] trim_reg, trim_next;
    logic             brk_valid_reg, brk_valid_next;
    logic [LEN_W-1:0] brk_pos_reg, brk_pos_next;
    logic [LEN_W-1:0] brk_trim_reg, brk_trim_next;
    logic [7:0]       brk_char_reg, brk_char_next;
    logic             skip_reg, skip_next;

    // Emission state
    logic [PTR_W-1:0] base_reg;
    logic [LEN_W-1:0] span_reg;
    logic [LEN_W-1:0] total_reg;
    logic [7:0]       ext0_reg;
    logic [7:0]       ext1_reg;
    logic [LEN_W-1:0] idx_reg;
    logic [7:0]       pend_first_reg;
    logic [7:0]       pend_second_reg;
    logic [1:0]       pend_cnt_reg;
    logic             out_valid_reg;
    logic [7:0]       out_first_reg;
    logic [7:0]       out_second_reg;
    logic [1:0]       out_cnt_reg;
    logic             out_last_reg;

    logic             is_w;
    logic             is_sp;
    logic             is_nl;
    logic             drop;
    logic             full;
    logic             wr_en;
    logic [LEN_W-1:0] fill_inc;
    logic [LEN_W-1:0] cut_pos;
    logic [LEN_W-1:0] span_acc;
    logic [1:0]       ext_cnt;
    logic [7:0]       ext0_acc;
    logic [7:0]       ext1_acc;
    logic [LEN_W-1:0] total_acc;
    logic [PTR_W-1:0] wr_addr;
    logic [PTR_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    logic [7:0]       byte_sel;

    // Classify the incoming byte and decide what the line does with it
    always_comb
    begin
        is_w     = is_word(ch);
        is_sp    = (ch == CH_SPACE);
        is_nl    = (ch == CH_NEWLINE);
        fill_inc = fill_reg + LEN_W'(1);
        drop     = is_sp && (fill_reg == '0) && skip_reg;
        full     = (fill_reg == LEN_W'(LINE_WIDTH));
        cut_pos  = brk_valid_reg ? brk_pos_reg : LEN_W'(LINE_WIDTH - 1);

        fill_next      = fill_reg;
        start_next     = start_reg;
        trim_next      = trim_reg;
        brk_valid_next = brk_valid_reg;
        brk_pos_next   = brk_pos_reg;
        brk_trim_next  = brk_trim_reg;
        brk_char_next  = brk_char_reg;
        skip_next      = skip_reg;
        wr_en          = 1'b0;
        span_acc       = '0;
        ext_cnt        = 2'd0;
        ext0_acc       = CH_NEWLINE;
        ext1_acc       = CH_NEWLINE;

        if (cmd.accept && !drop)
        begin
            wr_en = 1'b1;
            priority if (full && !is_w)
            begin
                // Full on a break: send the line as is, then a newline
                span_acc       = is_sp ? LEN_W'(LINE_WIDTH) : LEN_W'(LINE_WIDTH + 1);
                ext_cnt        = 2'd1;
                fill_next      = '0;
                trim_next      = '0;
                brk_valid_next = 1'b0;
                skip_next      = 1'b1;
            end
            else if (full)
            begin
                // Full on a word byte: cut at the last break, carry the tail
                span_acc = brk_valid_reg ? brk_trim_reg : LEN_W'(LINE_WIDTH);
                if (brk_valid_reg && (brk_char_reg != CH_SPACE))
                begin
                    ext0_acc = brk_char_reg;
                    ext_cnt  = 2'd2;
                end
                else
                begin
                    ext_cnt = 2'd1;
                end
                start_next     = wrap_add(start_reg, cut_pos + LEN_W'(1));
                fill_next      = LEN_W'(LINE_WIDTH) - cut_pos;
                trim_next      = LEN_W'(LINE_WIDTH) - cut_pos;
                brk_valid_next = 1'b0;
                skip_next      = 1'b1;
            end
            else if (is_nl)
            begin
                // Newline flush; a lone byte is dropped
                if (last_byte)
                begin
                    span_acc = (fill_inc == LEN_W'(2)) ? '0 : trim_reg;
                end
                else
                begin
                    span_acc = (fill_inc == LEN_W'(1)) ? '0 : fill_inc;
                end
                fill_next      = '0;
                trim_next      = '0;
                brk_valid_next = 1'b0;
                skip_next      = 1'b0;
            end
            else
            begin
                // Plain append: track trimmed length and last break
                fill_next = fill_inc;
                if (!is_sp)
                begin
                    trim_next = fill_inc;
                end
                if (!is_w)
                begin
                    brk_valid_next = 1'b1;
                    brk_pos_next   = fill_reg;
                    brk_trim_next  = trim_reg;
                    brk_char_next  = ch;
                end
            end
        end
        total_acc = span_acc + LEN_W'(ext_cnt);
    end

    assign wr_addr  = wrap_add(start_reg, fill_reg);
    assign rd_addr  = wrap_add(base_reg, idx_reg);
    assign byte_sel = (idx_reg < span_reg) ? rd_data :
                      ((idx_reg == span_reg) ? ext0_reg : ext1_reg);

    tlw_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (ch),
        .rd_en   (cmd.issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Line tracking registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            start_reg     <= '0;
            trim_reg      <= '0;
            brk_valid_reg <= 1'b0;
            skip_reg      <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            start_reg     <= start_next;
            trim_reg      <= trim_next;
            brk_valid_reg <= brk_valid_next;
            skip_reg      <= skip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        brk_pos_reg  <= brk_pos_next;
        brk_trim_reg <= brk_trim_next;
        brk_char_reg <= brk_char_next;
    end

    // Emission control: byte index, pair assembly, output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg       <= '0;
            idx_reg         <= '0;
            pend_cnt_reg    <= 2'd0;
            pend_second_reg <= 8'h00;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                total_reg       <= total_acc;
                idx_reg         <= '0;
                pend_cnt_reg    <= 2'd0;
                pend_second_reg <= 8'h00;
            end
            else if (cmd.take)
            begin
                if (pend_cnt_reg != 2'd0)
                begin
                    pend_second_reg <= byte_sel;
                end
                pend_cnt_reg <= pend_cnt_reg + 2'd1;
                idx_reg      <= idx_reg + LEN_W'(1);
            end
            else if (cmd.load)
            begin
                pend_cnt_reg    <= 2'd0;
                pend_second_reg <= 8'h00;
            end

            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            base_reg <= start_reg;
            span_reg <= span_acc;
            ext0_reg <= ext0_acc;
            ext1_reg <= ext1_acc;
        end
        if (cmd.take && (pend_cnt_reg == 2'd0))
        begin
            pend_first_reg <= byte_sel;
        end
        if (cmd.load)
        begin
            out_first_reg  <= pend_first_reg;
            out_second_reg <= pend_second_reg;
            out_cnt_reg    <= pend_cnt_reg;
            out_last_reg   <= (idx_reg == total_reg);
        end
    end

    assign status.more     = (idx_reg < total_reg);
    assign status.pend_one = (pend_cnt_reg == 2'd1);
    assign status.pend_any = (pend_cnt_reg != 2'd0);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign char_first  = out_first_reg;
    assign char_second = out_second_reg;
    assign pair_count  = out_cnt_reg;
    assign end_of_run  = out_last_reg;

    // A result holds one or two bytes
    a_pair_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_cnt_reg == 2'd1) || (out_cnt_reg == 2'd2)))
        else $error("result with bad byte count");

    // A single-byte result carries zero in its second byte
    a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_cnt_reg == 2'd1)) |-> (out_second_reg == 8'h00))
        else $error("single-byte result with nonzero second byte");

    // The line never holds more than a full wrap width between bytes
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= LEN_W'(LINE_WIDTH)) && (idx_reg <= total_reg))
        else $error("fill or emission index out of range");

endmodule

@@ design/tlw_ctrl.sv @@
module tlw_ctrl import tlw_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  tlw_status_t status,
    output tlw_cmd_t    cmd
);

    tlw_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence: take a byte, then read, collect and send result pairs
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (status.more)
                begin
                    cmd.issue  = 1'b1;
                    state_next = ST_TAKE;
                end
                else if (status.pend_any)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TAKE:
            begin
                cmd.take   = 1'b1;
                state_next = status.pend_one ? ST_LOAD : ST_ISSUE;
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.more ? ST_ISSUE : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A byte is taken only the cycle after its memory read
    a_take_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> $past(cmd.issue))
        else $error("take without a preceding read");

    // Loading a pair empties the pair assembly
    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !status.pend_any)
        else $error("pair assembly not empty after load");

endmodule

@@ design/text_line_wrapper.sv @@
// Sequence: a byte that causes no result returns from ST_ISSUE to ST_IDLE; otherwise
// each result pair is read from the line memory one byte at a time (ST_ISSUE, ST_TAKE)
// and registered in ST_LOAD, which waits while the output is held. A new byte is
// accepted only in ST_IDLE, after every result of the previous byte has been loaded.
// Reset: rst_n is asynchronous, active low, and clears the control state; the line
// memory is not cleared and needs no clearing pass.
module text_line_wrapper import tlw_pkg::*; #(
    parameter int LINE_WIDTH = 80
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] char_first, [15:8] char_second, [17:16] pair_count
    output logic        m_tlast    // end_of_run
);

    tlw_cmd_t    cmd;
    tlw_status_t status;
    logic [7:0]  char_first;
    logic [7:0]  char_second;
    logic [1:0]  pair_count;

    tlw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tlw_datapath #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .ch          (s_tdata),
        .last_byte   (s_tlast),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .char_first  (char_first),
        .char_second (char_second),
        .pair_count  (pair_count),
        .end_of_run  (m_tlast)
    );

    // Pack the result fields, zero-filled to whole bytes
    assign m_tdata = {6'b000000, pair_count, char_second, char_first};

endmodule

@@ bench/text_line_wrapper_checker.sv @@
`timescale 1ns / 100ps

module text_line_wrapper_checker import tlw_pkg::*; #(
    parameter int LINE_WIDTH = 80
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // last_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [7:0] char_first, [15:8] char_second, [17:16] pair_count
    input  logic        m_tlast,   // end_of_run
    output int          fail_count,
    output int          pairs_waiting
);

    localparam int WRAP_FILL = LINE_WIDTH + 1;

    typedef struct packed {
        logic [7:0] first_ch;
        logic [7:0] second_ch;
        logic [1:0] count;
        logic       run_end;
    } char_pair_t;

    // Shadow copy of the wrapper state
    logic [7:0] line_mem [0:LINE_WIDTH+1];
    int         line_fill;
    bit         skip_spaces;

    char_pair_t pending_pairs [$];

    initial
    begin
        line_fill     = 0;
        skip_spaces   = 1'b0;
        fail_count    = 0;
        pairs_waiting = 0;
    end

    function automatic bit is_alnum(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]});
    endfunction

    // Work out the bytes one input byte sends and queue them two per transfer
    task automatic wrap_byte(input logic [7:0] ch, input logic last_flag);
        logic [7:0] sent [$];
        char_pair_t pair;
        int         brk_at;
        int         keep;
        int         tail;
        int         j;
        int         k;

        // Drop a leading space after a wrap
        if (ch == CH_SPACE && line_fill == 0 && skip_spaces)
            return;
        line_mem[line_fill] = ch;
        line_fill++;

        if (line_fill == WRAP_FILL)
        begin
            if (!is_alnum(ch))
            begin
                // Full on a break: send the line as is, minus a newest space
                if (ch == CH_SPACE)
                    line_fill--;
                for (k = 0; k < line_fill; k++)
                    sent.push_back(line_mem[k]);
                sent.push_back(CH_NEWLINE);
                line_fill = 0;
            end
            else
            begin
                brk_at = -1;
                for (j = LINE_WIDTH - 1; j >= 0 && brk_at < 0; j--)
                    if (!is_alnum(line_mem[j]))
                        brk_at = j;
                if (brk_at >= 0)
                begin
                    // Wrap at the last break, carry the tail over
                    keep = brk_at;
                    while (keep > 0 && line_mem[keep-1] == CH_SPACE)
                        keep--;
                    for (k = 0; k < keep; k++)
                        sent.push_back(line_mem[k]);
                    if (line_mem[brk_at] != CH_SPACE)
                        sent.push_back(line_mem[brk_at]);
                    sent.push_back(CH_NEWLINE);
                    tail = LINE_WIDTH - brk_at;
                    for (k = 0; k < tail; k++)
                        line_mem[k] = line_mem[brk_at + 1 + k];
                    line_fill = tail;
                end
                else
                begin
                    // No break at all: force the first LINE_WIDTH bytes out
                    for (k = 0; k < LINE_WIDTH; k++)
                        sent.push_back(line_mem[k]);
                    sent.push_back(CH_NEWLINE);
                    line_mem[0] = line_mem[LINE_WIDTH];
                    line_fill = 1;
                end
            end
            skip_spaces = 1'b1;
        end

        // Flush on newline; a lone byte left over is a blank line and vanishes
        if (line_fill != 0 && ch == CH_NEWLINE)
        begin
            keep = line_fill;
            if (last_flag)
                keep--;
            if (keep != 1)
            begin
                while (keep > 0 && line_mem[keep-1] == CH_SPACE)
                    keep--;
                for (k = 0; k < keep; k++)
                    sent.push_back(line_mem[k]);
            end
            line_fill   = 0;
            skip_spaces = 1'b0;
        end

        for (k = 0; k < sent.size(); k += 2)
        begin
            pair.first_ch  = sent[k];
            pair.second_ch = (k + 1 < sent.size()) ? sent[k+1] : 8'h00;
            pair.count     = (k + 1 < sent.size()) ? 2'd2 : 2'd1;
            pair.run_end   = (k + 2 >= sent.size());
            pending_pairs.push_back(pair);
        end
    endtask

    // Check output transfers before predicting so a stray result is never masked
    always @(posedge clk)
    begin
        char_pair_t got;
        char_pair_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata[7:0], m_tdata[15:8], m_tdata[17:16], m_tlast};
                if (pending_pairs.size() == 0)
                begin
                    $display("%0t: unexpected transfer %h last %b", $time, m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = pending_pairs.pop_front();
                    if (got.first_ch !== want.first_ch)
                    begin
                        $display("%0t: char_first expected %h actual %h",
                                 $time, want.first_ch, got.first_ch);
                        fail_count++;
                    end
                    if (got.second_ch !== want.second_ch)
                    begin
                        $display("%0t: char_second expected %h actual %h",
                                 $time, want.second_ch, got.second_ch);
                        fail_count++;
                    end
                    if (got.count !== want.count)
                    begin
                        $display("%0t: pair_count expected %0d actual %0d",
                                 $time, want.count, got.count);
                        fail_count++;
                    end
                    if (got.run_end !== want.run_end)
                    begin
                        $display("%0t: end_of_run expected %b actual %b",
                                 $time, want.run_end, got.run_end);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                wrap_byte(s_tdata, s_tlast);
            pairs_waiting = pending_pairs.size();
        end
    end

endmodule

@@ bench/text_line_wrapper_tb.sv @@
`timescale 1ns / 100ps

module text_line_wrapper_tb;
    import tlw_pkg::*;

    // Default line width
    localparam int LINE_WIDTH  = 80;
    localparam int TOTAL_ITEMS = 270;
    localparam int CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] ch
    logic        s_tlast;   // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [7:0] char_first, [15:8] char_second, [17:16] pair_count
    logic        m_tlast;   // end_of_run

    int          fail_count;
    int          pairs_waiting;
    int          item_count;
    int          cycle_count;
    bit          steady;
    logic [8:0]  opening [0:20];

    text_line_wrapper #(
        .LINE_WIDTH(LINE_WIDTH)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    text_line_wrapper_checker #(
        .LINE_WIDTH(LINE_WIDTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .pairs_waiting(pairs_waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("text_line_wrapper_tb failed");
            $finish;
        end
    end

    // Stall the output side about ten percent of the time, never during the steady stretch
    always @(posedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= 10);

    function automatic logic [7:0] word_char();
        case ($urandom_range(0, 2))
            0:       return 8'h30 + 8'($urandom_range(0, 9));
            1:       return 8'h41 + 8'($urandom_range(0, 25));
            default: return 8'h61 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] break_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]});
        return c;
    endfunction

    // Offer one byte, with an occasional gap before it, and hold until transfer
    task automatic send_byte(input logic [7:0] ch, input logic last_flag);
        if (!steady && $urandom_range(0, 99) < 10)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last_flag;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        item_count++;
        steady = (item_count >= 130 && item_count < 200);
    endtask

    initial
    begin
        int len;
        int kind;
        int k;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        item_count  = 0;
        cycle_count = 0;
        steady      = 1'b0;

        // {last_byte, ch}: kept space, blank line, field extremes and class edges,
        // newline on the last byte, a one-byte line, an unfinished line
        opening = '{
            {1'b0, CH_SPACE}, {1'b0, CH_NEWLINE}, {1'b0, CH_NEWLINE},
            9'h000, 9'h0ff, 9'h030, 9'h039, 9'h041, 9'h05a, 9'h061, 9'h07a,
            9'h02f, 9'h03a, 9'h040, 9'h05b, 9'h060, 9'h07b,
            {1'b1, CH_NEWLINE}, 9'h078, {1'b1, CH_NEWLINE}, 9'h171
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            send_byte(opening[i][7:0], opening[i][8]);

        // Mostly words and separators, some space runs and raw noise
        while (item_count < TOTAL_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                len = ($urandom_range(0, 9) == 0) ?
                      $urandom_range(LINE_WIDTH, LINE_WIDTH + 6) : $urandom_range(1, 7);
                for (k = 0; k < len && item_count < TOTAL_ITEMS; k++)
                    send_byte(word_char(), $urandom_range(0, 99) < 3);
                kind = $urandom_range(0, 99);
                if (kind < 60)
                    repeat ($urandom_range(1, 2)) send_byte(CH_SPACE, 1'b0);
                else if (kind < 75)
                    send_byte(CH_NEWLINE, $urandom_range(0, 9) == 0);
                else if (kind < 90)
                    send_byte(break_char(), $urandom_range(0, 9) == 0);
                else
                begin
                    send_byte(CH_SPACE, 1'b0);
                    send_byte(CH_NEWLINE, 1'($urandom_range(0, 1)));
                end
            end
            else if (kind < 85)
                repeat ($urandom_range(1, 4)) send_byte(CH_SPACE, $urandom_range(0, 19) == 0);
            else
                repeat ($urandom_range(1, 5))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        // Drain, then watch a while for stray results
        while (pairs_waiting != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (fail_count == 0)
            $display("text_line_wrapper_tb passed");
        else
            $display("text_line_wrapper_tb failed");
        $finish;
    end

endmodule
